/* rtl/ird_pkg.sv */
// Shared types, constants and helpers for the radix digit converter.
// Depends on nothing; every rtl file refers to it by scoped names.
`default_nettype none

package ird_pkg;

  // Field widths
  localparam int unsigned VALUE_W = 31;
  localparam int unsigned RADIX_W = 6;
  localparam int unsigned CHAR_W  = 7;

  // Digit store default depth
  localparam int unsigned DIGIT_CAPACITY = 32;

  // Radix limits and reset value
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;

  // Divider: quotient bits resolved per cycle, padded dividend width
  localparam int unsigned DIV_STEP   = 4;
  localparam int unsigned DIV_CYCLES = (VALUE_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DIV_W      = DIV_CYCLES * DIV_STEP;
  localparam int unsigned DIV_CNT_W  = $clog2(DIV_CYCLES + 1);

  // ASCII codes
  localparam logic [CHAR_W-1:0]  ASCII_ZERO = 7'd48;
  localparam logic [CHAR_W-1:0]  ASCII_A    = 7'd65;
  localparam logic [RADIX_W-1:0] DEC_DIGITS = 6'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  typedef struct packed {
    logic               start;
    logic [VALUE_W-1:0] dividend;
    logic [RADIX_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [VALUE_W-1:0] quotient;
    logic [RADIX_W-1:0] remainder;
  } div_rsp_t;

  // Clamp a programmed radix into the supported range
  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end else begin
      res = r;
    end
    return res;
  endfunction

  // Map a digit value to '0'-'9' or 'A'-'Z'
  function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] res;
    if (d < DEC_DIGITS) begin
      res = ASCII_ZERO + CHAR_W'(d);
    end else begin
      res = ASCII_A + CHAR_W'(d - DEC_DIGITS);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/ird_div.sv */
// Iterative restoring divider: 31-bit dividend by a 6-bit divisor,
// DIV_STEP quotient bits per cycle. Depends on ird_pkg.
`default_nettype none

module ird_div (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ird_pkg::div_req_t req_i,
  output ird_pkg::div_rsp_t      rsp_o
);

  logic [ird_pkg::DIV_W-1:0]     shreg_q, shreg_d;
  logic [ird_pkg::RADIX_W-1:0]   rem_q, rem_d;
  logic [ird_pkg::RADIX_W-1:0]   divisor_q;
  logic [ird_pkg::DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [ird_pkg::DIV_W-1:0]     sh_step;
  logic [ird_pkg::RADIX_W:0]     rem_step;

  // Resolve DIV_STEP quotient bits, MSB first
  always_comb begin
    sh_step  = shreg_q;
    rem_step = {1'b0, rem_q};
    for (int i = 0; i < int'(ird_pkg::DIV_STEP); i++) begin
      rem_step = {rem_step[ird_pkg::RADIX_W-1:0], sh_step[ird_pkg::DIV_W-1]};
      sh_step  = {sh_step[ird_pkg::DIV_W-2:0], 1'b0};
      if (rem_step >= {1'b0, divisor_q}) begin
        rem_step   = rem_step - {1'b0, divisor_q};
        sh_step[0] = 1'b1;
      end
    end
  end

  // Load on start, advance while busy, pulse done after the last step
  always_comb begin
    shreg_d = shreg_q;
    rem_d   = rem_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    if (req_i.start) begin
      shreg_d = ird_pkg::DIV_W'(req_i.dividend);
      rem_d   = '0;
      cnt_d   = ird_pkg::DIV_CNT_W'(ird_pkg::DIV_CYCLES);
      busy_d  = 1'b1;
    end else if (busy_q) begin
      shreg_d = sh_step;
      rem_d   = rem_step[ird_pkg::RADIX_W-1:0];
      cnt_d   = cnt_q - 1'b1;
      if (cnt_q == ird_pkg::DIV_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath registers hold without reset
  always_ff @(posedge clk_i) begin
    shreg_q <= shreg_d;
    rem_q   <= rem_d;
    if (req_i.start) begin
      divisor_q <= req_i.divisor;
    end
  end

  assign rsp_o.busy      = busy_q;
  assign rsp_o.done      = done_q;
  assign rsp_o.quotient  = shreg_q[ird_pkg::VALUE_W-1:0];
  assign rsp_o.remainder = rem_q;

endmodule

`default_nettype wire

/* rtl/ird_store.sv */
// Digit store: one write port, one registered read port.
// Depends on ird_pkg for the digit width.
`default_nettype none

module ird_store #(
  parameter int unsigned Depth = ird_pkg::DIGIT_CAPACITY,
  localparam int unsigned IdxW = $clog2(Depth)
) (
  input  wire logic                        clk_i,
  input  wire logic                        we_i,
  input  wire logic [IdxW-1:0]             waddr_i,
  input  wire logic [ird_pkg::RADIX_W-1:0] wdata_i,
  input  wire logic                        re_i,
  input  wire logic [IdxW-1:0]             raddr_i,
  output logic      [ird_pkg::RADIX_W-1:0] rdata_o
);

  logic [ird_pkg::RADIX_W-1:0] mem_q [Depth];

  // Write remainders as they come out of the divider
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

/* rtl/integer_to_radix_digits.sv */
// Top level: sequencer, radix register, output register; instantiates
// ird_div and ird_store. Depends on ird_pkg.
//
//  channel | signals                                 | direction
//  cfg     | cfg_valid_i, cfg_ready_o, cfg_radix_i   | in  (radix write)
//  in      | in_valid_i, in_ready_o, value_i         | in  (one value per beat)
//  out     | out_valid_o, out_ready_i, digit_char_o, | out (one digit per beat,
//          | last_o                                  |      MSD first)
//
// For each digit of a value, the sequencer passes a start state, waits on
// the DIV_CYCLES iterations of the shared divider and stores the remainder;
// then, per digit, it reads the digit store and loads the output
// register.
// in_ready_o is high only while the sequencer is idle. A stalled output
// holds the sequencer in the emit phase. Reset is asynchronous, active low,
// and sets the radix to 10; the digit store needs no clearing.
`default_nettype none

module integer_to_radix_digits #(
  parameter int unsigned DigitCapacity = ird_pkg::DIGIT_CAPACITY,
  localparam int unsigned IdxW = $clog2(DigitCapacity),
  localparam int unsigned CntW = $clog2(DigitCapacity + 1)
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [ird_pkg::RADIX_W-1:0] cfg_radix_i,
  input  wire logic                        in_valid_i,
  output logic                             in_ready_o,
  input  wire logic [ird_pkg::VALUE_W-1:0] value_i,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [ird_pkg::CHAR_W-1:0]  digit_char_o,
  output logic                             last_o
);

  ird_pkg::state_e             state_q, state_d;
  logic [ird_pkg::RADIX_W-1:0] radix_q;
  logic [ird_pkg::RADIX_W-1:0] radix_eff_q, radix_eff_d;
  logic [ird_pkg::VALUE_W-1:0] dividend_q, dividend_d;
  logic [CntW-1:0]             cnt_q, cnt_d;
  logic [IdxW-1:0]             ptr_q, ptr_d;
  logic                        out_valid_q, out_valid_d;
  logic [ird_pkg::CHAR_W-1:0]  digit_q, digit_d;
  logic                        last_q, last_d;
  logic                        slot_free;
  logic                        store_we;
  logic                        store_re;
  logic [ird_pkg::RADIX_W-1:0] store_rdata;
  ird_pkg::div_req_t           div_req;
  ird_pkg::div_rsp_t           div_rsp;

  assign cfg_ready_o = 1'b1;
  assign slot_free   = !out_valid_q || out_ready_i;

  // Radix register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= ird_pkg::RADIX_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      radix_q <= cfg_radix_i;
    end
  end

  // Sequencer: accept, divide digit by digit, emit from the top down
  always_comb begin
    state_d     = state_q;
    radix_eff_d = radix_eff_q;
    dividend_d  = dividend_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    digit_d     = digit_q;
    last_d      = last_q;
    in_ready_o  = 1'b0;
    store_we    = 1'b0;
    store_re    = 1'b0;
    div_req.start    = 1'b0;
    div_req.dividend = dividend_q;
    div_req.divisor  = radix_eff_q;
    unique case (state_q)
      ird_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          dividend_d  = value_i;
          radix_eff_d = ird_pkg::clamp_radix(radix_q);
          cnt_d       = '0;
          state_d     = ird_pkg::ST_DIV_START;
        end
      end
      ird_pkg::ST_DIV_START: begin
        div_req.start = 1'b1;
        state_d       = ird_pkg::ST_DIV_WAIT;
      end
      ird_pkg::ST_DIV_WAIT: begin
        if (div_rsp.done) begin
          if (cnt_q < CntW'(DigitCapacity)) begin
            store_we = 1'b1;
            cnt_d    = cnt_q + 1'b1;
          end
          ptr_d      = IdxW'(cnt_d - 1'b1);
          dividend_d = div_rsp.quotient;
          if (div_rsp.quotient == '0) begin
            state_d = ird_pkg::ST_EMIT_RD;
          end else begin
            state_d = ird_pkg::ST_DIV_START;
          end
        end
      end
      ird_pkg::ST_EMIT_RD: begin
        store_re = 1'b1;
        state_d  = ird_pkg::ST_EMIT_LD;
      end
      ird_pkg::ST_EMIT_LD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          digit_d     = ird_pkg::digit_ascii(store_rdata);
          last_d      = (ptr_q == '0);
          if (ptr_q == '0) begin
            state_d = ird_pkg::ST_IDLE;
          end else begin
            ptr_d   = ptr_q - 1'b1;
            state_d = ird_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ird_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ird_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    radix_eff_q <= radix_eff_d;
    dividend_q  <= dividend_d;
    ptr_q       <= ptr_d;
    digit_q     <= digit_d;
    last_q      <= last_d;
  end

  ird_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  ird_store #(
    .Depth (DigitCapacity)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (div_rsp.remainder),
    .re_i    (store_re),
    .raddr_i (ptr_q),
    .rdata_o (store_rdata)
  );

  assign out_valid_o  = out_valid_q;
  assign digit_char_o = digit_q;
  assign last_o       = last_q;

`ifndef SYNTHESIS
  // Divider never runs while a new value can be taken
  a_idle_div_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !div_rsp.busy && !div_rsp.done)
    else $error("divider active while idle");

  // Each remainder is a valid digit of the current radix
  a_rem_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> div_rsp.remainder < radix_eff_q)
    else $error("remainder not below radix");

  // Digit count stays within the store
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(DigitCapacity))
    else $error("digit count beyond capacity");

  // Every presented digit is a legal ASCII digit
  a_char_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (digit_char_o >= 7'd48 && digit_char_o <= 7'd57) ||
                    (digit_char_o >= 7'd65 && digit_char_o <= 7'd90))
    else $error("digit character out of range");
`endif

endmodule

`default_nettype wire
